[design/sxt_pkg.sv]
`default_nettype none
package sxt_pkg;

    localparam int KEY_W         = 21;
    localparam int TABLE_ENTRIES = 16;
    localparam int ENTRY_BYTES   = 4;

    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic        last;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic        entry_is_codepoint;
        logic [20:0] entry_key;
        logic [2:0]  entry_length;
        logic [31:0] entry_bytes;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_end;
        logic       string_end;
        logic [1:0] error_code;
    } t_res;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UTF8  = 2'd1,
        ERR_TRUNC = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TBL,
        OP_RAW,
        OP_UTF8,
        OP_CP,
        OP_ESC,
        OP_ERR
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_HEXX,
        PH_HEXU,
        PH_UTF8
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_EMIT
    } t_state;

    // word passed from the parser to the emitter
    typedef struct packed {
        t_op         op;
        logic [20:0] val;
        logic        last;
        t_err        err;
        logic [3:0]  tidx;
        logic        tvalid;
        logic        tkind;
        logic [2:0]  tlen;
        logic [31:0] tbytes;
    } t_cmd;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_U   = 8'h75;

endpackage
`default_nettype wire

[design/sxt_fifo.sv]
`default_nettype none
module sxt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end
endmodule
`default_nettype wire

[design/sxt_front.sv]
`default_nettype none
module sxt_front
    import sxt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_named,
    input  wire logic i_take,
    input  wire t_in  i_in,
    output logic      o_enq,
    output t_cmd      o_cmd
);
    t_phase      r_phase, n_phase;
    logic [15:0] r_hex, n_hex;
    logic [2:0]  r_dig, n_dig;
    logic [1:0]  r_rem, n_rem;
    logic [20:0] r_uacc, n_uacc;
    logic        r_drop, n_drop;
    logic [3:0]  w_hv;
    logic [7:0]  b;
    t_err        w_err;

    assign b = i_in.data_byte;

    always_comb begin
        if (b >= 8'h30 && b <= 8'h39) w_hv = 4'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46) w_hv = 4'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h66) w_hv = 4'(b - 8'h57);
        else w_hv = 4'd0;
    end

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_dig   = r_dig;
        n_rem   = r_rem;
        n_uacc  = r_uacc;
        n_drop  = r_drop;
        w_err   = ERR_NONE;
        o_enq   = 1'b0;
        o_cmd   = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.err  = ERR_NONE;
        o_cmd.last = i_in.last;
        if (i_take && i_in.action) begin
            o_enq       = 1'b1;
            o_cmd.op    = OP_TBL;
            o_cmd.last  = 1'b0;
            o_cmd.val   = i_in.entry_key;
            o_cmd.tidx  = i_in.entry_index;
            o_cmd.tvalid = i_in.entry_valid;
            o_cmd.tkind = i_in.entry_is_codepoint;
            o_cmd.tlen  = i_in.entry_length;
            o_cmd.tbytes = i_in.entry_bytes;
        end else if (i_take) begin
            if (r_drop) begin
                if (i_in.last) begin
                    n_drop = 1'b0;
                end
            end else begin
                case (r_phase)
                    PH_ESC: begin
                        if (b == CH_X || b == CH_U) begin
                            n_phase = (b == CH_X) ? PH_HEXX : PH_HEXU;
                            n_hex   = '0;
                            n_dig   = '0;
                        end else begin
                            o_cmd.op  = OP_ESC;
                            o_cmd.val = {13'd0, b};
                            n_phase   = PH_IDLE;
                        end
                    end
                    PH_HEXX, PH_HEXU: begin
                        n_hex = {r_hex[11:0], w_hv};
                        n_dig = r_dig + 3'd1;
                        if (r_phase == PH_HEXX && n_dig >= 3'd2) begin
                            o_cmd.op  = OP_RAW;
                            o_cmd.val = {13'd0, n_hex[7:0]};
                            n_phase   = PH_IDLE;
                        end else if (r_phase == PH_HEXU && n_dig >= 3'd4) begin
                            o_cmd.op  = i_named ? OP_CP : OP_UTF8;
                            o_cmd.val = {5'd0, n_hex};
                            n_phase   = PH_IDLE;
                        end
                    end
                    PH_UTF8: begin
                        if (b[7:6] != 2'b10) begin
                            w_err = ERR_UTF8;
                        end else begin
                            n_uacc = {r_uacc[14:0], b[5:0]};
                            n_rem  = r_rem - 2'd1;
                            if (n_rem == 2'd0) begin
                                o_cmd.op  = OP_CP;
                                o_cmd.val = n_uacc;
                                n_phase   = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (b == CH_BSL) begin
                            n_phase = PH_ESC;
                        end else if (!i_named) begin
                            o_cmd.op  = OP_RAW;
                            o_cmd.val = {13'd0, b};
                        end else if (!b[7]) begin
                            o_cmd.op  = OP_CP;
                            o_cmd.val = {13'd0, b};
                        end else if (b[7:5] == 3'b110) begin
                            n_uacc = {16'd0, b[4:0]};
                            n_rem = 2'd1;
                            n_phase = PH_UTF8;
                        end else if (b[7:4] == 4'b1110) begin
                            n_uacc = {17'd0, b[3:0]};
                            n_rem = 2'd2;
                            n_phase = PH_UTF8;
                        end else if (b[7:3] == 5'b11110) begin
                            n_uacc = {18'd0, b[2:0]};
                            n_rem = 2'd3;
                            n_phase = PH_UTF8;
                        end else begin
                            w_err = ERR_UTF8;
                        end
                    end
                endcase
                if (i_in.last && w_err == ERR_NONE && n_phase != PH_IDLE) begin
                    w_err = ERR_TRUNC;
                end
                if (w_err != ERR_NONE) begin
                    o_cmd.op  = OP_ERR;
                    o_cmd.err = w_err;
                    n_drop    = !i_in.last;
                end
            end
            if (w_err != ERR_NONE || i_in.last) begin
                n_phase = PH_IDLE;
                n_hex   = '0;
                n_dig   = '0;
                n_rem   = '0;
                n_uacc  = '0;
            end
            o_enq = (o_cmd.op != OP_NONE) || i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hex   <= '0;
            r_dig   <= '0;
            r_rem   <= '0;
            r_uacc  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_dig   <= n_dig;
            r_rem   <= n_rem;
            r_uacc  <= n_uacc;
            r_drop  <= n_drop;
        end
    end
endmodule
`default_nettype wire

[design/sxt_back.sv]
`default_nettype none
module sxt_back
    import sxt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_empty,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_res      o_res
);
    localparam int IW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OUT_MAX = (ENTRY_BYTES > 3) ? ENTRY_BYTES : 3;
    localparam int KW      = $clog2(OUT_MAX + 1);
    localparam int BW      = $clog2(OUT_MAX);
    localparam int TW      = $clog2(ENTRY_BYTES + 1);

    logic                     r_used [TABLE_ENTRIES];
    logic                     r_kind [TABLE_ENTRIES];
    logic [KEY_W-1:0]         r_key  [TABLE_ENTRIES];
    logic [TW-1:0]            r_tcnt [TABLE_ENTRIES];
    logic [31:0]              r_pay  [TABLE_ENTRIES];

    t_state                   r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic [TABLE_ENTRIES-1:0] r_hit, n_hit;
    logic [7:0]               r_bytes [OUT_MAX];
    logic [7:0]               n_bytes [OUT_MAX];
    logic [KW-1:0]            r_cnt, n_cnt, r_k, n_k;
    logic                     r_bval, n_bval;
    logic                     w_we;
    logic [IW-1:0]            w_waddr, w_sel;
    logic                     w_found;
    logic [TW-1:0]            w_len;
    logic [15:0]              w_cp;

    assign w_waddr = IW'(i_cmd.tidx);
    assign w_cp    = r_cmd.val[15:0];
    assign w_len   = (32'(i_cmd.tlen) > ENTRY_BYTES) ? TW'(ENTRY_BYTES) : TW'(i_cmd.tlen);

    // first used slot that matched wins
    always_comb begin
        w_sel   = '0;
        w_found = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                w_sel   = IW'(i);
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_hit      = r_hit;
        n_bytes    = r_bytes;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_bval     = r_bval;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_we       = 1'b0;
        o_res.out_byte   = r_bval ? r_bytes[r_k[BW-1:0]] : 8'd0;
        o_res.byte_valid = r_bval;
        o_res.run_end    = (r_k == r_cnt - 1'b1);
        o_res.string_end = (r_k == r_cnt - 1'b1) && r_cmd.last;
        o_res.error_code = r_cmd.err;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_TBL) begin
                        w_we = (32'(i_cmd.tidx) < TABLE_ENTRIES);
                    end else begin
                        n_cmd   = i_cmd;
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    n_hit[i] = r_used[i] && r_key[i] == r_cmd.val &&
                               ((r_cmd.op == OP_CP && r_kind[i]) ||
                                (r_cmd.op == OP_ESC && !r_kind[i]));
                end
                n_state = ST_SEL;
            end
            ST_SEL: begin
                for (int j = 0; j < OUT_MAX; j++) begin
                    n_bytes[j] = 8'd0;
                end
                n_bval = 1'b1;
                n_cnt  = '0;
                n_k    = '0;
                case (r_cmd.op)
                    OP_RAW: begin
                        n_bytes[0] = r_cmd.val[7:0];
                        n_cnt      = KW'(1);
                    end
                    OP_UTF8: begin
                        if (w_cp == 16'd0) begin
                            n_cnt = '0;
                        end else if (w_cp <= 16'h7F) begin
                            n_bytes[0] = w_cp[7:0];
                            n_cnt      = KW'(1);
                        end else if (w_cp <= 16'h7FF) begin
                            n_bytes[0] = {3'b110, w_cp[10:6]};
                            n_bytes[1] = {2'b10, w_cp[5:0]};
                            n_cnt      = KW'(2);
                        end else begin
                            n_bytes[0] = {4'b1110, w_cp[15:12]};
                            n_bytes[1] = {2'b10, w_cp[11:6]};
                            n_bytes[2] = {2'b10, w_cp[5:0]};
                            n_cnt      = KW'(3);
                        end
                    end
                    OP_CP, OP_ESC: begin
                        if (w_found) begin
                            for (int j = 0; j < OUT_MAX; j++) begin
                                if (j < 4) begin
                                    n_bytes[j] = r_pay[w_sel][8*j +: 8];
                                end
                            end
                            n_cnt = KW'(r_tcnt[w_sel]);
                        end else begin
                            n_bytes[0] = (r_cmd.op == OP_CP) ? 8'hFF : r_cmd.val[7:0];
                            n_cnt      = KW'(1);
                        end
                    end
                    OP_ERR: begin
                        n_bval = 1'b0;
                        n_cnt  = KW'(1);
                    end
                    default: begin
                        n_cnt = '0;
                    end
                endcase
                // string end with nothing to show still closes the string
                if (n_cnt == '0 && r_cmd.last) begin
                    n_bval = 1'b0;
                    n_cnt  = KW'(1);
                end
                n_state = (n_cnt == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_k        = r_k + 1'b1;
                    if (r_k == r_cnt - 1'b1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_hit   <= n_hit;
        r_bytes <= n_bytes;
        r_cnt   <= n_cnt;
        r_k     <= n_k;
        r_bval  <= n_bval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_used[i] <= 1'b0;
            end
        end else if (w_we) begin
            r_used[w_waddr] <= i_cmd.tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && i_cmd.tvalid) begin
            r_kind[w_waddr] <= i_cmd.tkind;
            r_key[w_waddr]  <= i_cmd.val;
            r_tcnt[w_waddr] <= w_len;
            r_pay[w_waddr]  <= i_cmd.tbytes;
        end
    end

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_k < r_cnt)
        else $error("emit index past run length");

    a_push_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> r_state == ST_EMIT)
        else $error("result pushed outside emit");

    a_sel_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEL |=> (r_state == ST_EMIT || r_state == ST_IDLE))
        else $error("select stage did not finish");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == ST_IDLE && !i_cmd_empty))
        else $error("command popped while busy");
endmodule
`default_nettype wire

[design/string_escape_translator_unit.sv]
// String-literal escape translator. Bytes enter through a queue-style port
// (push/full) and translated bytes leave through another (pop/empty); a
// parser front end accepts one byte or table write per cycle while the
// command queue of CMD_DEPTH words is not full, and the emitter behind it
// takes a table write while idle and runs a string byte that yields N results
// (0 to 4) through its compare, select and one-result-per-cycle emit steps,
// the emit stalling while the result queue is full. A byte dropped after an
// error costs the emitter nothing unless it ends the string. The command queue
// lets the front end take bytes while the emitter is busy. The user writes
// named_mode through the cfg port while the block is idle; it is not enforced.
`default_nettype none
module string_escape_translator_unit
    import sxt_pkg::*;
#(
    parameter int CMD_DEPTH     = 4,
    parameter int RES_DEPTH     = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_in  i_in,
    output logic      empty,
    input  wire logic pop,
    output t_res      o_out,
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic i_cfg_data
);
    logic r_named;
    logic w_take, w_enq, w_cmd_empty, w_cmd_pop, w_res_full, w_res_push;
    t_cmd w_cmd_in, w_cmd_out;
    t_res w_res;

    assign o_cfg_ready = 1'b1;
    assign w_take      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_named <= 1'b0;
        end else if (i_cfg_valid) begin
            r_named <= i_cfg_data;
        end
    end

    sxt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_named (r_named),
        .i_take  (w_take),
        .i_in    (i_in),
        .o_enq   (w_enq),
        .o_cmd   (w_cmd_in)
    );

    sxt_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_enq),
        .i_wdata (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_cmd_out),
        .o_full  (full),
        .o_empty (w_cmd_empty)
    );

    sxt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    sxt_fifo #(.WIDTH($bits(t_res)), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .i_pop   (pop),
        .o_rdata (o_out),
        .o_full  (w_res_full),
        .o_empty (empty)
    );
endmodule
`default_nettype wire

[dv/string_escape_translator_unit_tb.sv]
`timescale 1ns / 1ps
module string_escape_translator_unit_tb
    import sxt_pkg::*;
();

    localparam int N_SLOTS   = 16;
    localparam int MAX_BYTES = 4;
    localparam int LIMIT     = 400000;

    typedef enum logic [2:0] {
        P_IDLE,
        P_ESC,
        P_HEXX,
        P_HEXU,
        P_UTF8
    } t_parse;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in  i_in = '0;
    logic empty;
    logic pop = 1'b0;
    t_res o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    string_escape_translator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // translator state mirrored by the testbench
    logic        mode_named;
    logic        slot_used [N_SLOTS];
    logic        slot_cp   [N_SLOTS];
    logic [20:0] slot_key  [N_SLOTS];
    logic [2:0]  slot_cnt  [N_SLOTS];
    logic [31:0] slot_data [N_SLOTS];
    t_parse      phase;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic [1:0]  u8_left;
    logic [20:0] u8_acc;
    logic        dropping;

    t_in  pending_words[$];
    t_res expected_bytes[$];
    t_res step_res[$];

    int errors = 0;
    int n_strings = 0;
    int n_results = 0;
    int n_errs = 0;
    int n_sent = 0;
    int cycles = 0;
    logic calm = 1'b0;
    logic drain_hold = 1'b0;
    int push_gap = 0;
    int pop_gap = 0;

    function automatic logic [3:0] hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9") return 4'(b - "0");
        if (b >= "A" && b <= "F") return 4'(b - "A" + 10);
        if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
        return 4'd0;
    endfunction

    task automatic add_byte(logic [7:0] b, logic v, t_err e);
        t_res r;
        r = '0;
        r.out_byte = b;
        r.byte_valid = v;
        r.error_code = e;
        step_res.push_back(r);
    endtask

    task automatic table_hit(logic kind, logic [20:0] key, output logic hit);
        hit = 1'b0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (!hit && slot_used[i] && slot_cp[i] == kind && slot_key[i] == key) begin
                hit = 1'b1;
                for (int j = 0; j < slot_cnt[i]; j++)
                    add_byte(slot_data[i][8*j +: 8], 1'b1, ERR_NONE);
            end
        end
    endtask

    task automatic emit_cp(logic [20:0] cp);
        logic hit;
        table_hit(1'b1, cp, hit);
        if (!hit) add_byte(8'hFF, 1'b1, ERR_NONE);
    endtask

    task automatic emit_utf8_bytes(logic [15:0] cp);
        if (cp == 0) return;
        if (cp <= 16'h7F) begin
            add_byte(cp[7:0], 1'b1, ERR_NONE);
        end else if (cp <= 16'h7FF) begin
            add_byte({3'b110, cp[10:6]}, 1'b1, ERR_NONE);
            add_byte({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end else begin
            add_byte({4'b1110, cp[15:12]}, 1'b1, ERR_NONE);
            add_byte({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
            add_byte({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end
    endtask

    task automatic clear_parse();
        phase = P_IDLE;
        hex_acc = '0;
        hex_cnt = '0;
        u8_left = '0;
        u8_acc = '0;
    endtask

    // work out the translated bytes of one accepted word
    task automatic translate(t_in w);
        t_err e;
        logic hit;
        e = ERR_NONE;
        step_res.delete();
        if (w.action) begin
            slot_used[w.entry_index] = w.entry_valid;
            if (w.entry_valid) begin
                slot_cp[w.entry_index]   = w.entry_is_codepoint;
                slot_key[w.entry_index]  = w.entry_key;
                slot_cnt[w.entry_index]  = (w.entry_length > MAX_BYTES) ? 3'(MAX_BYTES)
                                                                      : w.entry_length;
                slot_data[w.entry_index] = w.entry_bytes;
            end
            return;
        end
        if (dropping) begin
            if (!w.last) return;
            dropping = 1'b0;
            clear_parse();
        end else begin
            case (phase)
                P_ESC: begin
                    if (w.data_byte == CH_X || w.data_byte == CH_U) begin
                        phase = (w.data_byte == CH_X) ? P_HEXX : P_HEXU;
                        hex_acc = '0;
                        hex_cnt = '0;
                    end else begin
                        table_hit(1'b0, 21'(w.data_byte), hit);
                        if (!hit) add_byte(w.data_byte, 1'b1, ERR_NONE);
                        phase = P_IDLE;
                    end
                end
                P_HEXX, P_HEXU: begin
                    hex_acc = {hex_acc[11:0], hex_digit(w.data_byte)};
                    hex_cnt = hex_cnt + 3'd1;
                    if (phase == P_HEXX && hex_cnt >= 2) begin
                        add_byte(hex_acc[7:0], 1'b1, ERR_NONE);
                        phase = P_IDLE;
                    end else if (phase == P_HEXU && hex_cnt >= 4) begin
                        if (mode_named) emit_cp(21'(hex_acc));
                        else emit_utf8_bytes(hex_acc);
                        phase = P_IDLE;
                    end
                end
                P_UTF8: begin
                    if (w.data_byte[7:6] != 2'b10) begin
                        e = ERR_UTF8;
                    end else begin
                        u8_acc = {u8_acc[14:0], w.data_byte[5:0]};
                        u8_left = u8_left - 2'd1;
                        if (u8_left == 0) begin
                            emit_cp(u8_acc);
                            phase = P_IDLE;
                        end
                    end
                end
                default: begin
                    phase = P_IDLE;
                    if (w.data_byte == CH_BSL) begin
                        phase = P_ESC;
                    end else if (!mode_named) begin
                        add_byte(w.data_byte, 1'b1, ERR_NONE);
                    end else if (!w.data_byte[7]) begin
                        emit_cp(21'(w.data_byte));
                    end else if (w.data_byte[7:5] == 3'b110) begin
                        u8_acc = 21'(w.data_byte[4:0]); u8_left = 2'd1; phase = P_UTF8;
                    end else if (w.data_byte[7:4] == 4'b1110) begin
                        u8_acc = 21'(w.data_byte[3:0]); u8_left = 2'd2; phase = P_UTF8;
                    end else if (w.data_byte[7:3] == 5'b11110) begin
                        u8_acc = 21'(w.data_byte[2:0]); u8_left = 2'd3; phase = P_UTF8;
                    end else begin
                        e = ERR_UTF8;
                    end
                end
            endcase
            if (w.last && e == ERR_NONE && phase != P_IDLE) e = ERR_TRUNC;
            if (e != ERR_NONE) begin
                add_byte(8'h00, 1'b0, e);
                clear_parse();
                if (!w.last) dropping = 1'b1;
            end
            if (w.last) clear_parse();
        end
        if (w.last && step_res.size() == 0) add_byte(8'h00, 1'b0, ERR_NONE);
        foreach (step_res[k]) begin
            step_res[k].run_end    = (k == step_res.size() - 1);
            step_res[k].string_end = w.last && (k == step_res.size() - 1);
            expected_bytes.push_back(step_res[k]);
        end
    endtask

    // driver: a burst of idle cycles now and then, none once calm
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                translate(i_in);
                void'(pending_words.pop_front());
                n_sent <= n_sent + 1;
            end
            if (push_gap > 0) push_gap <= push_gap - 1;
            if (push && !full) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    push <= 1'b0;
                    push_gap <= $urandom_range(1, 5);
                end else if (pending_words.size() > 0 && !drain_hold) begin
                    i_in <= pending_words[0];
                end else begin
                    push <= 1'b0;
                end
            end else if (!push && push_gap <= 1 && pending_words.size() > 0 && !drain_hold) begin
                push <= 1'b1;
                i_in <= pending_words[0];
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        t_res exp_r;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (pop && !empty) begin
                n_results <= n_results + 1;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected word out_byte=%0h", o_out.out_byte);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_bytes.pop_front();
                    if (o_out.error_code != 0) n_errs <= n_errs + 1;
                    if (o_out.string_end) n_strings <= n_strings + 1;
                    if (o_out.out_byte !== exp_r.out_byte) begin
                        $error("out_byte exp %0h got %0h", exp_r.out_byte, o_out.out_byte);
                        errors <= errors + 1;
                    end
                    if (o_out.byte_valid !== exp_r.byte_valid) begin
                        $error("byte_valid exp %0b got %0b", exp_r.byte_valid,
                               o_out.byte_valid);
                        errors <= errors + 1;
                    end
                    if (o_out.run_end !== exp_r.run_end) begin
                        $error("run_end exp %0b got %0b", exp_r.run_end, o_out.run_end);
                        errors <= errors + 1;
                    end
                    if (o_out.string_end !== exp_r.string_end) begin
                        $error("string_end exp %0b got %0b", exp_r.string_end,
                               o_out.string_end);
                        errors <= errors + 1;
                    end
                    if (o_out.error_code !== exp_r.error_code) begin
                        $error("error_code exp %0d got %0d", exp_r.error_code,
                               o_out.error_code);
                        errors <= errors + 1;
                    end
                end
            end
            if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                pop <= 1'b0;
                pop_gap <= $urandom_range(0, 4);
            end else begin
                pop <= 1'b1;
            end
        end
        if (cycles > LIMIT) begin
            $display("string_escape_translator_unit: mismatch");
            $finish;
        end
    end

    function automatic t_in data_word(logic [7:0] b, logic l);
        t_in w;
        w = '0;
        w.data_byte = b;
        w.last = l;
        return w;
    endfunction

    task automatic queue_str(string s);
        for (int i = 0; i < s.len(); i++)
            pending_words.push_back(data_word(s[i], i == s.len() - 1));
    endtask

    task automatic queue_table(logic [3:0] idx, logic v, logic cp, logic [20:0] key,
                               logic [2:0] len, logic [31:0] bytes);
        t_in w;
        w = '0;
        w.action = 1'b1;
        w.entry_index = idx;
        w.entry_valid = v;
        w.entry_is_codepoint = cp;
        w.entry_key = key;
        w.entry_length = len;
        w.entry_bytes = bytes;
        w.data_byte = 8'($urandom);
        w.last = 1'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic wait_drain();
        while (pending_words.size() > 0 || push) @(posedge i_clk);
        while (expected_bytes.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mode_named = m;
        i_cfg_valid <= 1'b0;
    endtask

    // random string content: mostly well-formed escapes and UTF-8
    task automatic queue_random_string();
        int n;
        int kind;
        t_in w;
        logic [7:0] bytes_q[$];
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    bytes_q.push_back(CH_BSL); bytes_q.push_back(CH_X);
                    bytes_q.push_back("0" + $urandom_range(0, 9));
                    bytes_q.push_back("a" + $urandom_range(0, 5));
                end
                1: begin
                    bytes_q.push_back(CH_BSL); bytes_q.push_back(CH_U);
                    for (int j = 0; j < 4; j++)
                        bytes_q.push_back($urandom_range(0, 1) ? "0" + $urandom_range(0, 9)
                                                             : "A" + $urandom_range(0, 5));
                end
                2: begin
                    bytes_q.push_back(CH_BSL);
                    bytes_q.push_back($urandom_range(0, 1) ? "n" : 8'($urandom));
                end
                3: begin
                    bytes_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                    bytes_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
                end
                4: begin
                    bytes_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    bytes_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
                    bytes_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
                end
                5: begin
                    bytes_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                    for (int j = 0; j < 3; j++)
                        bytes_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
                end
                6: bytes_q.push_back(8'($urandom));
                default: bytes_q.push_back("a" + $urandom_range(0, 25));
            endcase
        end
        // occasionally truncate the string
        if ($urandom_range(0, 7) == 0 && bytes_q.size() > 1) void'(bytes_q.pop_back());
        foreach (bytes_q[i]) begin
            w = data_word(bytes_q[i], i == bytes_q.size() - 1);
            pending_words.push_back(w);
        end
    endtask

    initial begin
        int total;
        foreach (slot_used[i]) begin
            slot_used[i] = 1'b0; slot_cp[i] = 1'b0; slot_key[i] = '0;
            slot_cnt[i] = '0; slot_data[i] = '0;
        end
        mode_named = 1'b0;
        dropping = 1'b0;
        clear_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain mode: raw bytes, \x, \u to UTF-8 lengths, codepoint zero, escapes
        queue_str("A\\x7f");
        queue_str("\\xzz\\xFF");
        queue_str("\\u0000");
        queue_str("\\u07FF\\uffff");
        queue_table(4'd15, 1'b1, 1'b0, 21'h6E, 3'd7, 32'hDDCCBBAA);
        queue_str("\\n\\q");
        queue_str("\\u1");
        pending_words.push_back(data_word(8'hFF, 1'b1));
        wait_drain();

        set_mode(1'b1);
        queue_table(4'd0, 1'b1, 1'b1, 21'h1FFFFF, 3'd0, 32'h0);
        queue_table(4'd1, 1'b1, 1'b1, 21'h41, 3'd2, 32'h00004241);
        queue_table(4'd2, 1'b1, 1'b1, 21'h10FFFF, 3'd4, 32'h01020304);
        queue_str("AB");
        queue_str("\xf4\x8f\xbf\xbf");
        queue_str("\xff");
        queue_str("\xc3Z");
        queue_str("\xe2\x82");
        queue_str("\\u0041");
        queue_table(4'd1, 1'b0, 1'b1, 21'h41, 3'd2, 32'h0);
        queue_str("A");
        wait_drain();

        // random strings with a mode switch after every twenty of them
        total = 0;
        while (n_sent + pending_words.size() < 350) begin
            if ($urandom_range(0, 5) == 0)
                queue_table(4'($urandom), 1'($urandom_range(0, 3) != 0), 1'($urandom),
                            $urandom_range(0, 3) == 0 ? 21'($urandom)
                                                      : 21'($urandom_range(0, 8'hFF)),
                            3'($urandom), $urandom);
            queue_random_string();
            total = total + 1;
            if (total % 20 == 0) begin
                wait_drain();
                set_mode(1'($urandom));
            end
        end
        // hold off the sender until every expected result has come
        drain_hold = 1'b1;
        while (push || expected_bytes.size() > 0) @(posedge i_clk);
        drain_hold = 1'b0;
        wait_drain();
        set_mode(1'b0);
        calm = 1'b1;
        for (int i = 0; i < 10; i++) queue_random_string();
        wait_drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d strings, %0d result words, %0d error words",
                 n_strings, n_results, n_errs);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("string_escape_translator_unit: match");
        end else begin
            $display("string_escape_translator_unit: mismatch");
        end
        $finish;
    end

endmodule
